/* rtl/core/life_automaton_grid_step_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the life automaton grid step block
// Concurrent assertion shorthands with clock and active-low reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_AUTOMATON_GRID_STEP_MACROS_SVH
`define LIFE_AUTOMATON_GRID_STEP_MACROS_SVH

// Same-cycle implication.
`define LAGS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lags assertion failed");

// Next-cycle implication.
`define LAGS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lags assertion failed");

`endif

/* rtl/core/lags_pkg.sv */
// ----------------------------------------------------------------------------
// Life automaton grid step package
// Field widths, request codes and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lags_pkg;

    localparam int ACTION_W = 2;
    localparam int COORD_W  = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2
    } t_action;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_REQ,
        ST_RD_RESP,
        ST_WR_REQ,
        ST_WR_RESP,
        ST_RUP,
        ST_RMID,
        ST_RDN,
        ST_LDN,
        ST_CELL,
        ST_WROW
    } t_state;

endpackage

/* rtl/core/lags_ifs.sv */
// ----------------------------------------------------------------------------
// Life automaton grid step channels
// Request channel (write, read, step) and read response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lags_req_if;
    logic                         valid;
    logic                         ready;
    logic [lags_pkg::ACTION_W-1:0] action;
    logic [lags_pkg::COORD_W-1:0]  column;
    logic [lags_pkg::COORD_W-1:0]  row;
    logic                         cell_in;

    modport source (output valid, output action, output column, output row,
                    output cell_in, input ready);
    modport sink   (input valid, input action, input column, input row,
                    input cell_in, output ready);
endinterface

interface lags_rsp_if;
    logic valid;
    logic ready;
    logic cell_out;

    modport source (output valid, output cell_out, input ready);
    modport sink   (input valid, input cell_out, output ready);
endinterface

/* rtl/core/life_automaton_grid_step.sv */
// ----------------------------------------------------------------------------
// Life automaton grid step
// Toroidal B3/S23 cell grid with cell write, cell read and generation step.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                         Accepted when
// i_req     in   action, column, row, cell_in    valid && ready
// o_rsp     out  cell_out (read requests only)   valid && ready
//
// A write request passes through a read state and a write-back state; a read
// request passes through a read state and a response state that waits for the
// response register. In a step request, per row, one memory read port fetches
// three rows and a single cell evaluator walks the columns. After reset a
// clearing pass empties the grid before the first request is taken. A stalled
// response holds a pending read request in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "life_automaton_grid_step_macros.svh"

module life_automaton_grid_step #(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 96
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lags_req_if.sink     i_req,
    lags_rsp_if.source   o_rsp
);

    localparam int COL_W     = $clog2(GRID_WIDTH);
    localparam int ROW_W     = $clog2(GRID_HEIGHT);
    localparam int ADDR_W    = ROW_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam logic [COL_W-1:0] X_MAX = COL_W'(GRID_WIDTH - 1);
    localparam logic [ROW_W-1:0] Y_MAX = ROW_W'(GRID_HEIGHT - 1);

    logic [GRID_WIDTH-1:0] r_mem [0:MEM_DEPTH-1];
    logic [GRID_WIDTH-1:0] r_rd_data;

    lags_pkg::t_state r_state, n_state;
    logic [ROW_W-1:0]      r_y, n_y;
    logic [COL_W-1:0]      r_x, n_x;
    logic                  r_sel, n_sel;
    logic [ROW_W-1:0]      r_row, n_row;
    logic [COL_W-1:0]      r_col, n_col;
    logic                  r_cell, n_cell;
    logic                  r_inside, n_inside;
    logic [GRID_WIDTH-1:0] r_up, n_up;
    logic [GRID_WIDTH-1:0] r_mid, n_mid;
    logic [GRID_WIDTH-1:0] r_dn, n_dn;
    logic [GRID_WIDTH-1:0] r_new, n_new;
    logic                  r_out_valid, n_out_valid;
    logic                  r_out_cell, n_out_cell;

    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [GRID_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [ADDR_W-1:0]     mem_raddr;

    logic req_fire;
    logic req_inside;
    logic out_free;

    assign req_fire   = i_req.valid && i_req.ready;
    assign req_inside = (32'(i_req.column) < 32'(GRID_WIDTH))
                     && (32'(i_req.row) < 32'(GRID_HEIGHT));
    assign out_free   = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lags_pkg::ST_CLEAR: begin
                if (r_y == Y_MAX) n_state = lags_pkg::ST_IDLE;
            end
            lags_pkg::ST_IDLE: begin
                if (req_fire) begin
                    unique case (lags_pkg::t_action'(i_req.action))
                        lags_pkg::ACT_WRITE: begin
                            if (req_inside) n_state = lags_pkg::ST_WR_REQ;
                        end
                        lags_pkg::ACT_READ:  n_state = lags_pkg::ST_RD_REQ;
                        lags_pkg::ACT_STEP:  n_state = lags_pkg::ST_RUP;
                        default:             n_state = lags_pkg::ST_IDLE;
                    endcase
                end
            end
            lags_pkg::ST_RD_REQ:  n_state = lags_pkg::ST_RD_RESP;
            lags_pkg::ST_RD_RESP: begin
                if (out_free) n_state = lags_pkg::ST_IDLE;
            end
            lags_pkg::ST_WR_REQ:  n_state = lags_pkg::ST_WR_RESP;
            lags_pkg::ST_WR_RESP: n_state = lags_pkg::ST_IDLE;
            lags_pkg::ST_RUP:     n_state = lags_pkg::ST_RMID;
            lags_pkg::ST_RMID:    n_state = lags_pkg::ST_RDN;
            lags_pkg::ST_RDN:     n_state = lags_pkg::ST_LDN;
            lags_pkg::ST_LDN:     n_state = lags_pkg::ST_CELL;
            lags_pkg::ST_CELL: begin
                if (r_x == X_MAX) n_state = lags_pkg::ST_WROW;
            end
            lags_pkg::ST_WROW: begin
                n_state = (r_y == Y_MAX) ? lags_pkg::ST_IDLE : lags_pkg::ST_RUP;
            end
            default: n_state = lags_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        logic [ROW_W-1:0] y_up;
        logic [ROW_W-1:0] y_dn;
        logic [COL_W-1:0] x_l;
        logic [COL_W-1:0] x_r;
        logic [3:0]       alive;
        logic [GRID_WIDTH-1:0] patched;

        y_up  = (r_y == '0) ? Y_MAX : r_y - ROW_W'(1);
        y_dn  = (r_y == Y_MAX) ? '0 : r_y + ROW_W'(1);
        x_l   = (r_x == '0) ? X_MAX : r_x - COL_W'(1);
        x_r   = (r_x == X_MAX) ? '0 : r_x + COL_W'(1);
        alive = 4'(r_up[x_l]) + 4'(r_up[r_x]) + 4'(r_up[x_r])
              + 4'(r_mid[x_l]) + 4'(r_mid[x_r])
              + 4'(r_dn[x_l]) + 4'(r_dn[r_x]) + 4'(r_dn[x_r]);
        patched = r_rd_data;
        patched[r_col] = r_cell;

        n_y         = r_y;
        n_x         = r_x;
        n_sel       = r_sel;
        n_row       = r_row;
        n_col       = r_col;
        n_cell      = r_cell;
        n_inside    = r_inside;
        n_up        = r_up;
        n_mid       = r_mid;
        n_dn        = r_dn;
        n_new       = r_new;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_out_cell  = r_out_cell;
        mem_we      = 1'b0;
        mem_waddr   = {r_sel, r_row};
        mem_wdata   = patched;
        mem_re      = 1'b0;
        mem_raddr   = {r_sel, r_row};
        i_req.ready = (r_state == lags_pkg::ST_IDLE);

        unique case (r_state)
            lags_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = {1'b0, r_y};
                mem_wdata = '0;
                n_y       = (r_y == Y_MAX) ? '0 : r_y + ROW_W'(1);
            end
            lags_pkg::ST_IDLE: begin
                if (req_fire) begin
                    n_row    = ROW_W'(i_req.row);
                    n_col    = COL_W'(i_req.column);
                    n_cell   = i_req.cell_in;
                    n_inside = req_inside;
                    n_y      = '0;
                end
            end
            lags_pkg::ST_RD_REQ,
            lags_pkg::ST_WR_REQ: begin
                mem_re = 1'b1;
            end
            lags_pkg::ST_RD_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_cell  = r_inside & r_rd_data[r_col];
                end
            end
            lags_pkg::ST_WR_RESP: begin
                mem_we = 1'b1;
            end
            lags_pkg::ST_RUP: begin
                mem_re    = 1'b1;
                mem_raddr = {r_sel, y_up};
            end
            lags_pkg::ST_RMID: begin
                mem_re    = 1'b1;
                mem_raddr = {r_sel, r_y};
                n_up      = r_rd_data;
            end
            lags_pkg::ST_RDN: begin
                mem_re    = 1'b1;
                mem_raddr = {r_sel, y_dn};
                n_mid     = r_rd_data;
            end
            lags_pkg::ST_LDN: begin
                n_dn = r_rd_data;
                n_x  = '0;
            end
            lags_pkg::ST_CELL: begin
                n_new[r_x] = (alive == 4'd3) || ((alive == 4'd2) && r_mid[r_x]);
                n_x        = (r_x == X_MAX) ? '0 : r_x + COL_W'(1);
            end
            lags_pkg::ST_WROW: begin
                mem_we    = 1'b1;
                mem_waddr = {~r_sel, r_y};
                mem_wdata = r_new;
                if (r_y == Y_MAX) begin
                    n_sel = ~r_sel;
                    n_y   = '0;
                end else begin
                    n_y = r_y + ROW_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.cell_out = r_out_cell;

    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rd_data <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lags_pkg::ST_CLEAR;
            r_y         <= '0;
            r_x         <= '0;
            r_sel       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_y         <= n_y;
            r_x         <= n_x;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_col      <= n_col;
        r_cell     <= n_cell;
        r_inside   <= n_inside;
        r_up       <= n_up;
        r_mid      <= n_mid;
        r_dn       <= n_dn;
        r_new      <= n_new;
        r_out_cell <= n_out_cell;
    end

    `LAGS_ASSERT_NOW(a_rsp_from_read, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == lags_pkg::ST_RD_RESP)
    `LAGS_ASSERT_NOW(a_step_writes_other, i_clk, i_rst_n, r_state == lags_pkg::ST_WROW, mem_waddr[ADDR_W-1] != r_sel)
    `LAGS_ASSERT_NEXT(a_swap_at_end, i_clk, i_rst_n, (r_state == lags_pkg::ST_WROW) && (r_y == Y_MAX), r_sel != $past(r_sel))
    `LAGS_ASSERT_NOW(a_no_read_write_clash, i_clk, i_rst_n, mem_we && mem_re, mem_waddr != mem_raddr)

endmodule

/* tb/sv/life_grid_compare.sv */
// ----------------------------------------------------------------------------
// Life grid response comparison
// Watches the request and response channels of the life automaton grid step
// block. It keeps its own copy of the toroidal B3/S23 grid, applies every
// accepted write and step to it, and compares each read response against the
// cell value that the copy holds at the time the read request was accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_grid_compare #(
    parameter int GRID_WIDTH  = 128,
    parameter int GRID_HEIGHT = 96
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lags_req_if   i_req,
    lags_rsp_if   i_rsp,
    output int    o_fail_count,
    output int    o_pending
);

    import lags_pkg::*;

    typedef struct {
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] row;
        logic               cell_value;
    } t_cell_read;

    t_cell_read read_expect[$];
    t_cell_read oldest_read;
    t_cell_read new_read;
    bit         life_now [GRID_HEIGHT][GRID_WIDTH];
    bit         life_next [GRID_HEIGHT][GRID_WIDTH];
    int         fail_total = 0;

    assign o_fail_count = fail_total;

    function automatic bit on_grid(input logic [COORD_W-1:0] column,
                                   input logic [COORD_W-1:0] row);
        return (int'(column) < GRID_WIDTH) && (int'(row) < GRID_HEIGHT);
    endfunction

    function void advance_life();
        int neighbors;
        for (int y = 0; y < GRID_HEIGHT; y++) begin
            for (int x = 0; x < GRID_WIDTH; x++) begin
                neighbors = 0;
                for (int dy = -1; dy <= 1; dy++) begin
                    for (int dx = -1; dx <= 1; dx++) begin
                        if (dy != 0 || dx != 0) begin
                            neighbors += life_now[(y + dy + GRID_HEIGHT) % GRID_HEIGHT]
                                                 [(x + dx + GRID_WIDTH) % GRID_WIDTH];
                        end
                    end
                end
                life_next[y][x] = (neighbors == 3) || (neighbors == 2 && life_now[y][x]);
            end
        end
        life_now = life_next;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (life_now[y, x]) life_now[y][x] = 1'b0;
            read_expect.delete();
            o_pending <= 0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                if (read_expect.size() == 0) begin
                    fail_total++;
                    $display("%0t: response with no read outstanding, expected none, got %0b",
                             $time, i_rsp.cell_out);
                end else begin
                    oldest_read = read_expect.pop_front();
                    if (i_rsp.cell_out !== oldest_read.cell_value) begin
                        fail_total++;
                        $display("%0t: read of cell (column %0d, row %0d) expected %0b, got %0b",
                                 $time, oldest_read.column, oldest_read.row,
                                 oldest_read.cell_value, i_rsp.cell_out);
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                case (i_req.action)
                    ACT_WRITE: begin
                        if (on_grid(i_req.column, i_req.row)) begin
                            life_now[i_req.row][i_req.column] = i_req.cell_in;
                        end
                    end
                    ACT_READ: begin
                        new_read.column     = i_req.column;
                        new_read.row        = i_req.row;
                        new_read.cell_value = on_grid(i_req.column, i_req.row) ?
                                              life_now[i_req.row][i_req.column] : 1'b0;
                        read_expect.push_back(new_read);
                    end
                    ACT_STEP: begin
                        advance_life();
                    end
                    default: begin
                    end
                endcase
            end
            o_pending <= read_expect.size();
        end
    end

endmodule

/* tb/sv/tb_life_automaton_grid_step.sv */
// ----------------------------------------------------------------------------
// Life automaton grid step testbench
// Drives cell writes, cell reads and generation steps into the block, with
// random gaps on the request side and random stalls on the response side.
// A directed opening covers grid corners, reads and writes off the grid, the
// unused request code and a blinker that oscillates across the wrapped edge.
// The random part loads small patches of cells, may step them, and reads
// the area back. A separate module predicts and checks every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_life_automaton_grid_step;

    import lags_pkg::*;

    localparam int GRID_WIDTH  = 128;
    localparam int GRID_HEIGHT = 96;
    localparam int STEP_CYCLES = GRID_HEIGHT * (GRID_WIDTH + 5);
    localparam int QUIET_LIMIT = 5 * STEP_CYCLES;
    localparam int ITEM_TARGET = 900;
    localparam int MAX_IDLE    = 17;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lags_req_if req_ch ();
    lags_rsp_if rsp_ch ();

    int fail_count;
    int pending_reads;
    int quiet_cycles = 0;
    int n_writes = 0;
    int n_reads = 0;
    int n_steps = 0;
    int n_unused = 0;
    int n_drains = 0;
    bit send_idle_on = 1'b0;
    bit rsp_stall_on = 1'b0;
    int rsp_hold = 0;

    life_automaton_grid_step #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    life_grid_compare #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT)
    ) u_compare (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_reads)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no request or response accepted for %0d cycles", $time,
                     quiet_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // After each accepted response the receiver may hold ready low for a while.
    initial begin
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                rsp_hold = 0;
                rsp_ch.ready <= 1'b0;
            end else if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_hold = rsp_stall_on ? $urandom_range(0, MAX_IDLE) : 0;
                rsp_ch.ready <= (rsp_hold == 0);
            end else if (rsp_hold != 0) begin
                rsp_hold = rsp_hold - 1;
                rsp_ch.ready <= (rsp_hold == 0);
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    function automatic int wrap(input int value, input int span);
        return ((value % span) + span) % span;
    endfunction

    task automatic send_req(input logic [ACTION_W-1:0] act, input int column,
                            input int row, input logic cell_val);
        int gap;
        gap = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.action  <= act;
        req_ch.column  <= column[COORD_W-1:0];
        req_ch.row     <= row[COORD_W-1:0];
        req_ch.cell_in <= cell_val;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        case (act)
            ACT_WRITE: n_writes++;
            ACT_READ:  n_reads++;
            ACT_STEP:  n_steps++;
            default:   n_unused++;
        endcase
    endtask

    task automatic drain_reads();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_reads != 0);
        n_drains++;
    endtask

    initial begin
        int center_x;
        int center_y;
        int count;
        int pick;

        req_ch.valid   <= 1'b0;
        req_ch.action  <= ACT_WRITE;
        req_ch.column  <= '0;
        req_ch.row     <= '0;
        req_ch.cell_in <= 1'b0;
        i_rst_n        <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Grid corners, off-grid accesses and the unused request code.
        send_req(ACT_READ, 0, 0, 1'b0);
        send_req(ACT_READ, 127, 127, 1'b0);
        send_req(ACT_WRITE, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b1);
        send_req(ACT_READ, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b0);
        send_req(ACT_WRITE, 5, 100, 1'b1);
        send_req(ACT_READ, 5, 100, 1'b0);
        send_req(ACT_UNUSED, 127, 127, 1'b1);
        send_req(ACT_WRITE, GRID_WIDTH - 1, GRID_HEIGHT - 1, 1'b0);

        // A blinker lying across the column wrap flips to vertical and back.
        send_req(ACT_WRITE, GRID_WIDTH - 1, 0, 1'b1);
        send_req(ACT_WRITE, 0, 0, 1'b1);
        send_req(ACT_WRITE, 1, 0, 1'b1);
        send_req(ACT_STEP, 0, 0, 1'b0);
        send_req(ACT_READ, 0, GRID_HEIGHT - 1, 1'b0);
        send_req(ACT_READ, 0, 1, 1'b0);
        send_req(ACT_READ, GRID_WIDTH - 1, 0, 1'b0);
        send_req(ACT_STEP, 0, 0, 1'b0);
        send_req(ACT_READ, 1, 0, 1'b0);
        send_req(ACT_READ, GRID_WIDTH - 1, 0, 1'b0);
        send_req(ACT_READ, 0, 1, 1'b0);
        drain_reads();

        // Patches of cells are loaded, maybe stepped and read back, with some noise.
        while (n_writes + n_reads + n_steps < ITEM_TARGET) begin
            send_idle_on = ($urandom_range(0, 3) != 0);
            rsp_stall_on = ($urandom_range(0, 3) != 0);
            center_x = $urandom_range(0, GRID_WIDTH - 1);
            center_y = $urandom_range(0, GRID_HEIGHT - 1);
            count = $urandom_range(4, 20);
            repeat (count) begin
                send_req(ACT_WRITE, wrap(center_x + $urandom_range(0, 6) - 3, GRID_WIDTH),
                         wrap(center_y + $urandom_range(0, 6) - 3, GRID_HEIGHT),
                         $urandom_range(0, 9) < 6);
            end
            pick = $urandom_range(0, 9);
            if (pick >= 4) send_req(ACT_STEP, 0, 0, 1'b0);
            if (pick == 9) send_req(ACT_STEP, 0, 0, 1'b0);
            count = $urandom_range(6, 20);
            repeat (count) begin
                send_req(ACT_READ, wrap(center_x + $urandom_range(0, 8) - 4, GRID_WIDTH),
                         wrap(center_y + $urandom_range(0, 8) - 4, GRID_HEIGHT), 1'b0);
            end
            count = $urandom_range(0, 3);
            repeat (count) begin
                send_req(ACTION_W'($urandom_range(0, 3)), $urandom_range(0, 127),
                         $urandom_range(0, 127), 1'($urandom_range(0, 1)));
            end
            if ($urandom_range(0, 7) == 0) drain_reads();
        end

        send_idle_on = 1'b0;
        repeat (4) begin
            send_req(ACT_READ, $urandom_range(0, GRID_WIDTH - 1),
                     $urandom_range(0, GRID_HEIGHT - 1), 1'b0);
        end
        drain_reads();
        repeat (STEP_CYCLES + 100) @(posedge i_clk);

        $display("Sent %0d writes, %0d reads, %0d generation steps and %0d unused codes.",
                 n_writes, n_reads, n_steps, n_unused);
        $display("The sender waited for every outstanding read %0d times.", n_drains);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/lags_pkg.sv
rtl/core/lags_ifs.sv
rtl/core/life_automaton_grid_step.sv
tb/sv/life_grid_compare.sv
tb/sv/tb_life_automaton_grid_step.sv
